[hw/rtl/pidl_pkg.sv]
// ----------------------------------------------------------------------------
// pidl_pkg
// Shared types and constants for the positional insert/delete list.
// ----------------------------------------------------------------------------
package pidl_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int POS_W         = 6;
    localparam int VALUE_W       = 32;

    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_DELETE = 2'd2,
        ACT_SHOW   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_BADPOS = 2'd2,
        STAT_EMPTY  = 2'd3
    } status_t;

    // One result item offered by the sequencer to the output stage.
    typedef struct packed {
        logic               valid;
        status_t            status;
        logic [VALUE_W-1:0] entry_value;
        logic [POS_W-1:0]   entry_index;
        logic               last;
    } result_t;

endpackage

[hw/rtl/pidl_ram.sv]
// ----------------------------------------------------------------------------
// pidl_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module pidl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/pidl_seq.sv]
// ----------------------------------------------------------------------------
// pidl_seq
// Item sequencer: keeps the fill count, walks the entry RAM for shifts and
// for show, and offers result items to the output stage.
// ----------------------------------------------------------------------------
module pidl_seq #(
    parameter int DEPTH = pidl_pkg::DEPTH_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_action,
    input  logic [pidl_pkg::POS_W-1:0]    s_position,
    input  logic [pidl_pkg::VALUE_W-1:0]  s_value,
    input  logic                          take,
    output pidl_pkg::result_t             res,
    output logic                          ram_we,
    output logic [$clog2(DEPTH)-1:0]      ram_waddr,
    output logic [pidl_pkg::VALUE_W-1:0]  ram_wdata,
    output logic                          ram_re,
    output logic [$clog2(DEPTH)-1:0]      ram_raddr,
    input  logic [pidl_pkg::VALUE_W-1:0]  ram_rdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    // compare width: holds position, fill count and either plus two
    localparam int XW = ((CW > pidl_pkg::POS_W) ? CW : pidl_pkg::POS_W) + 1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_UP   = 5'b00010,
        S_DN   = 5'b00100,
        S_SHOW = 5'b01000,
        S_RESP = 5'b10000
    } state_t;

    state_t                        state_reg, state_next;
    logic [CW-1:0]                 fill_reg, fill_next;
    logic [AW-1:0]                 cursor_reg, cursor_next;
    logic [AW-1:0]                 pos_reg, pos_next;
    logic [pidl_pkg::VALUE_W-1:0]  value_reg, value_next;
    pidl_pkg::status_t             status_reg, status_next;

    logic          fire;
    logic [XW-1:0] pos_x, fill_x, cursor_x;
    logic          full, empty, show_last;

    assign s_ready   = (state_reg == S_IDLE);
    assign fire      = s_valid && s_ready;
    assign pos_x     = XW'(s_position);
    assign fill_x    = XW'(fill_reg);
    assign cursor_x  = XW'(cursor_reg);
    assign full      = (fill_x == XW'(DEPTH));
    assign empty     = (fill_reg == '0);
    assign show_last = ((cursor_x + XW'(1)) == fill_x);

    always_comb begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        cursor_next = cursor_reg;
        pos_next    = pos_reg;
        value_next  = value_reg;
        status_next = status_reg;

        ram_we    = 1'b0;
        ram_waddr = cursor_reg;
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = cursor_reg;

        res.valid       = 1'b0;
        res.status      = status_reg;
        res.entry_value = '0;
        res.entry_index = '0;
        res.last        = 1'b1;

        unique case (state_reg)
            S_IDLE: begin
                if (fire) begin
                    value_next  = s_value;
                    pos_next    = AW'(s_position);
                    status_next = pidl_pkg::STAT_OK;
                    state_next  = S_RESP;
                    unique case (pidl_pkg::action_t'(s_action))
                        pidl_pkg::ACT_APPEND: begin
                            if (full) begin
                                status_next = pidl_pkg::STAT_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = AW'(fill_reg);
                                ram_wdata = s_value;
                                fill_next = fill_reg + CW'(1);
                            end
                        end
                        pidl_pkg::ACT_INSERT: begin
                            if (full) begin
                                status_next = pidl_pkg::STAT_FULL;
                            end else if (pos_x > fill_x) begin
                                status_next = pidl_pkg::STAT_BADPOS;
                            end else if (pos_x == fill_x) begin
                                ram_we    = 1'b1;
                                ram_waddr = AW'(fill_reg);
                                ram_wdata = s_value;
                                fill_next = fill_reg + CW'(1);
                            end else begin
                                // walk down from the top, one move per cycle
                                ram_re      = 1'b1;
                                ram_raddr   = AW'(fill_x - XW'(1));
                                cursor_next = AW'(fill_reg);
                                state_next  = S_UP;
                            end
                        end
                        pidl_pkg::ACT_DELETE: begin
                            if (empty) begin
                                status_next = pidl_pkg::STAT_EMPTY;
                            end else if (pos_x >= fill_x) begin
                                status_next = pidl_pkg::STAT_BADPOS;
                            end else if ((pos_x + XW'(1)) == fill_x) begin
                                fill_next = fill_reg - CW'(1);
                            end else begin
                                ram_re      = 1'b1;
                                ram_raddr   = AW'(pos_x + XW'(1));
                                cursor_next = AW'(s_position);
                                state_next  = S_DN;
                            end
                        end
                        pidl_pkg::ACT_SHOW: begin
                            if (empty) begin
                                status_next = pidl_pkg::STAT_EMPTY;
                            end else begin
                                ram_re      = 1'b1;
                                ram_raddr   = '0;
                                cursor_next = '0;
                                state_next  = S_SHOW;
                            end
                        end
                    endcase
                end
            end
            S_UP: begin
                ram_we      = 1'b1;
                ram_waddr   = cursor_reg;
                cursor_next = cursor_reg - AW'(1);
                if (cursor_reg == pos_reg) begin
                    ram_wdata  = value_reg;
                    fill_next  = fill_reg + CW'(1);
                    state_next = S_RESP;
                end else begin
                    ram_wdata = ram_rdata;
                    // fetch ahead of the write while more moves remain
                    if ((cursor_x - XW'(1)) != XW'(pos_reg)) begin
                        ram_re    = 1'b1;
                        ram_raddr = AW'(cursor_x - XW'(2));
                    end
                end
            end
            S_DN: begin
                ram_we      = 1'b1;
                ram_waddr   = cursor_reg;
                ram_wdata   = ram_rdata;
                cursor_next = cursor_reg + AW'(1);
                if ((cursor_x + XW'(2)) == fill_x) begin
                    fill_next  = fill_reg - CW'(1);
                    state_next = S_RESP;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(cursor_x + XW'(2));
                end
            end
            S_SHOW: begin
                res.valid       = 1'b1;
                res.status      = pidl_pkg::STAT_OK;
                res.entry_value = ram_rdata;
                res.entry_index = pidl_pkg::POS_W'(cursor_reg);
                res.last        = show_last;
                if (take) begin
                    if (show_last) begin
                        state_next = S_IDLE;
                    end else begin
                        ram_re      = 1'b1;
                        ram_raddr   = AW'(cursor_x + XW'(1));
                        cursor_next = AW'(cursor_x + XW'(1));
                    end
                end
            end
            S_RESP: begin
                res.valid = 1'b1;
                if (take) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
        end
        cursor_reg <= cursor_next;
        pos_reg    <= pos_next;
        value_reg  <= value_next;
        status_reg <= status_next;
    end

    a_append_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && (s_action == pidl_pkg::ACT_APPEND) && !full
        |=> fill_reg == $past(fill_reg) + CW'(1))
        else $error("append did not grow the fill count");

    a_no_write_on_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SHOW || state_reg == S_RESP) |-> !ram_we)
        else $error("RAM written while emitting results");

    a_write_in_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (XW'(ram_waddr) <= fill_x) && (XW'(ram_waddr) < XW'(DEPTH)))
        else $error("RAM write beyond the list");

    a_last_ends_item: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid && take && res.last |=> state_reg == S_IDLE)
        else $error("sequencer busy after final result");

endmodule

[hw/rtl/positional_insert_delete_list.sv]
// ----------------------------------------------------------------------------
// positional_insert_delete_list
// Ordered list of signed words with append, insert, delete and show-all.
// ----------------------------------------------------------------------------
// Items are taken one at a time; s_ready is high only while no item is in
// work, and a result register decouples m_ready from the next item. Insert
// below the end and delete below the last entry shift the entries between;
// show emits one entry per cycle while the result side does not stall. The
// shift walks are bound by the entry RAM's single write port, one entry
// moved per cycle. Entry storage needs no clearing after reset: only entries
// below the fill count are ever read.
module positional_insert_delete_list #(
    parameter int DEPTH = pidl_pkg::DEPTH_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_action,
    input  logic [pidl_pkg::POS_W-1:0]          s_position,
    input  logic signed [pidl_pkg::VALUE_W-1:0] s_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [1:0]                          m_status,
    output logic signed [pidl_pkg::VALUE_W-1:0] m_entry_value,
    output logic [pidl_pkg::POS_W-1:0]          m_entry_index,
    output logic                                m_last
);

    localparam int AW = $clog2(DEPTH);

    pidl_pkg::result_t             res;
    logic                          take;
    logic                          ram_we, ram_re;
    logic [AW-1:0]                 ram_waddr, ram_raddr;
    logic [pidl_pkg::VALUE_W-1:0]  ram_wdata, ram_rdata;

    logic                          m_valid_reg;
    logic [1:0]                    status_reg;
    logic [pidl_pkg::VALUE_W-1:0]  value_reg;
    logic [pidl_pkg::POS_W-1:0]    index_reg;
    logic                          last_reg;

    pidl_ram #(
        .WIDTH (pidl_pkg::VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pidl_seq #(
        .DEPTH (DEPTH)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_action   (s_action),
        .s_position (s_position),
        .s_value    (s_value),
        .take       (take),
        .res        (res),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata)
    );

    // result register: loads when empty or being drained this cycle
    assign take = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (take) begin
            m_valid_reg <= res.valid;
        end
        if (take && res.valid) begin
            status_reg <= res.status;
            value_reg  <= res.entry_value;
            index_reg  <= res.entry_index;
            last_reg   <= res.last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_entry_value = value_reg;
    assign m_entry_index = index_reg;
    assign m_last        = last_reg;

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the positional insert/delete list against a shadow copy of the list
// kept in the bench. Directed items cover empty-list and bad-position cases;
// random items sweep the list from empty to full and back, with bursty input
// and a stalling result side.
// ----------------------------------------------------------------------------
module tb;

    localparam int DEPTH       = pidl_pkg::DEPTH_DEFAULT;
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int N_RANDOM    = 350;

    typedef struct {
        pidl_pkg::action_t                     action;
        logic [pidl_pkg::POS_W-1:0]            position;
        logic signed [pidl_pkg::VALUE_W-1:0]   value;
        bit                                    hold;    // wait for all results before driving
    } list_req_t;

    typedef struct {
        pidl_pkg::status_t                     status;
        logic signed [pidl_pkg::VALUE_W-1:0]   entry_value;
        logic [pidl_pkg::POS_W-1:0]            entry_index;
        logic                                  last;
    } list_result_t;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PATTERN
    } rx_mode_t;

    logic                                  aclk = 1'b0;
    logic                                  aresetn = 1'b0;
    logic                                  s_valid = 1'b0;
    logic                                  s_ready;
    logic [1:0]                            s_action = pidl_pkg::ACT_APPEND;
    logic [pidl_pkg::POS_W-1:0]            s_position = '0;
    logic signed [pidl_pkg::VALUE_W-1:0]   s_value = '0;
    logic                                  m_valid;
    logic                                  m_ready = 1'b0;
    logic [1:0]                            m_status;
    logic signed [pidl_pkg::VALUE_W-1:0]   m_entry_value;
    logic [pidl_pkg::POS_W-1:0]            m_entry_index;
    logic                                  m_last;

    list_req_t     req_q[$];
    list_result_t  result_q[$];

    // shadow list, updated as each item goes onto the bus
    logic signed [pidl_pkg::VALUE_W-1:0]   list_words[DEPTH];
    int                                    list_fill = 0;

    int        plan_fill = 0;     // fill count as seen by the generator
    int        mismatches = 0;
    int        cycles = 0;
    int        burst_left = 0;
    int        gap_left = 0;
    rx_mode_t  rx_mode = RX_ALWAYS;
    int        rx_mode_left = 0;
    logic [15:0] rx_pattern = 16'hffff;

    positional_insert_delete_list #(.DEPTH(DEPTH)) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_position    (s_position),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_entry_value (m_entry_value),
        .m_entry_index (m_entry_index),
        .m_last        (m_last)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    task automatic queue_result(pidl_pkg::status_t st,
                                logic signed [pidl_pkg::VALUE_W-1:0] v, int idx, bit lst);
        list_result_t r;
        r.status      = st;
        r.entry_value = v;
        r.entry_index = idx[pidl_pkg::POS_W-1:0];
        r.last        = lst;
        result_q.push_back(r);
    endtask

    task automatic list_apply(input list_req_t req);
        int i;
        int p;
        p = req.position;
        case (req.action)
            pidl_pkg::ACT_APPEND: begin
                if (list_fill >= DEPTH) begin
                    queue_result(pidl_pkg::STAT_FULL, '0, 0, 1'b1);
                end else begin
                    list_words[list_fill] = req.value;
                    list_fill++;
                    queue_result(pidl_pkg::STAT_OK, '0, 0, 1'b1);
                end
            end
            pidl_pkg::ACT_INSERT: begin
                if (list_fill >= DEPTH) begin
                    queue_result(pidl_pkg::STAT_FULL, '0, 0, 1'b1);
                end else if (p > list_fill) begin
                    queue_result(pidl_pkg::STAT_BADPOS, '0, 0, 1'b1);
                end else begin
                    for (i = list_fill; i > p; i--)
                        list_words[i] = list_words[i-1];
                    list_words[p] = req.value;
                    list_fill++;
                    queue_result(pidl_pkg::STAT_OK, '0, 0, 1'b1);
                end
            end
            pidl_pkg::ACT_DELETE: begin
                if (list_fill == 0) begin
                    queue_result(pidl_pkg::STAT_EMPTY, '0, 0, 1'b1);
                end else if (p >= list_fill) begin
                    queue_result(pidl_pkg::STAT_BADPOS, '0, 0, 1'b1);
                end else begin
                    for (i = p; i + 1 < list_fill; i++)
                        list_words[i] = list_words[i+1];
                    list_fill--;
                    queue_result(pidl_pkg::STAT_OK, '0, 0, 1'b1);
                end
            end
            default: begin
                if (list_fill == 0) begin
                    queue_result(pidl_pkg::STAT_EMPTY, '0, 0, 1'b1);
                end else begin
                    for (i = 0; i < list_fill; i++)
                        queue_result(pidl_pkg::STAT_OK, list_words[i], i,
                                     i + 1 == list_fill);
                end
            end
        endcase
    endtask

    task automatic add_req(pidl_pkg::action_t a, int p, logic [pidl_pkg::VALUE_W-1:0] v,
                           bit hold);
        list_req_t r;
        r.action   = a;
        r.position = p[pidl_pkg::POS_W-1:0];
        r.value    = v;
        r.hold     = hold;
        req_q.push_back(r);
        case (a)
            pidl_pkg::ACT_APPEND: if (plan_fill < DEPTH) plan_fill++;
            pidl_pkg::ACT_INSERT: if (plan_fill < DEPTH && p <= plan_fill) plan_fill++;
            pidl_pkg::ACT_DELETE: if (plan_fill > 0 && p < plan_fill) plan_fill--;
            default: ;
        endcase
    endtask

    function automatic logic [pidl_pkg::VALUE_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    // stimulus
    initial begin
        int  n;
        int  r;
        int  hits;
        int  hit_limit;
        bit  growing;
        bit  hold;

        // directed: empty list, value extremes, edges of the position range
        add_req(pidl_pkg::ACT_SHOW,   0,  32'h0,         1'b0);
        add_req(pidl_pkg::ACT_DELETE, 0,  32'h0,         1'b0);
        add_req(pidl_pkg::ACT_DELETE, 63, 32'hffff_ffff, 1'b0);
        add_req(pidl_pkg::ACT_APPEND, 63, 32'h8000_0000, 1'b0);
        add_req(pidl_pkg::ACT_APPEND, 0,  32'h7fff_ffff, 1'b0);
        add_req(pidl_pkg::ACT_INSERT, 0,  32'hffff_ffff, 1'b0);
        add_req(pidl_pkg::ACT_INSERT, 3,  32'h0,         1'b0);   // at the end: acts as append
        add_req(pidl_pkg::ACT_INSERT, 5,  32'h1234_5678, 1'b0);   // past the end
        add_req(pidl_pkg::ACT_INSERT, 63, 32'h1234_5678, 1'b0);
        add_req(pidl_pkg::ACT_DELETE, 4,  32'h0,         1'b0);   // one past the last entry
        add_req(pidl_pkg::ACT_DELETE, 63, 32'h0,         1'b0);
        add_req(pidl_pkg::ACT_SHOW,   63, 32'hffff_ffff, 1'b0);
        add_req(pidl_pkg::ACT_DELETE, 0,  32'h0,         1'b0);
        add_req(pidl_pkg::ACT_DELETE, 2,  32'h0,         1'b0);   // last entry
        add_req(pidl_pkg::ACT_INSERT, 1,  32'h5555_5555, 1'b0);
        add_req(pidl_pkg::ACT_APPEND, 42, 32'haaaa_aaaa, 1'b0);
        add_req(pidl_pkg::ACT_SHOW,   0,  32'h0,         1'b0);
        add_req(pidl_pkg::ACT_DELETE, 1,  32'h0,         1'b0);
        add_req(pidl_pkg::ACT_DELETE, 0,  32'h0,         1'b0);
        add_req(pidl_pkg::ACT_DELETE, 1,  32'h0,         1'b0);
        add_req(pidl_pkg::ACT_DELETE, 0,  32'h0,         1'b0);
        add_req(pidl_pkg::ACT_SHOW,   21, 32'h0,         1'b0);

        // random: sweep toward full, linger, then drain toward empty
        growing   = 1'b1;
        hits      = 0;
        hit_limit = 2;
        for (n = 0; n < N_RANDOM; n++) begin
            r    = $urandom_range(0, 99);
            hold = (n == 0) || (n == N_RANDOM / 2);
            if (r < 8) begin
                add_req(pidl_pkg::ACT_SHOW, $urandom_range(0, 63), $urandom, hold);
            end else if (r < 16) begin
                add_req(pidl_pkg::action_t'($urandom_range(0, 3)), $urandom_range(0, 63),
                        pick_word(), hold);
            end else if (growing) begin
                if (plan_fill == DEPTH)
                    hits++;
                if (r < 55)
                    add_req(pidl_pkg::ACT_INSERT,
                            $urandom_range(0, plan_fill > 63 ? 63 : plan_fill),
                            pick_word(), hold);
                else
                    add_req(pidl_pkg::ACT_APPEND, $urandom_range(0, 63), pick_word(), hold);
            end else begin
                if (plan_fill == 0) begin
                    hits++;
                    add_req(pidl_pkg::ACT_DELETE, $urandom_range(0, 63), pick_word(), hold);
                end else begin
                    add_req(pidl_pkg::ACT_DELETE, $urandom_range(0, plan_fill - 1),
                            pick_word(), hold);
                end
            end
            if (hits >= hit_limit) begin
                growing   = !growing;
                hits      = 0;
                hit_limit = $urandom_range(1, 4);
            end
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        while (req_q.size() != 0 || s_valid || result_q.size() != 0)
            @(posedge aclk);
        repeat (100) @(posedge aclk);

        if (mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    // driver
    always @(posedge aclk) begin : driver
        list_req_t req;
        if (!aresetn) begin
            s_valid    <= 1'b0;
            s_action   <= pidl_pkg::ACT_APPEND;
            s_position <= '0;
            s_value    <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end else if (!s_valid || s_ready) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                s_valid  <= 1'b0;
            end else if (req_q.size() != 0 && !(req_q[0].hold && result_q.size() != 0)) begin
                req = req_q.pop_front();
                s_action   <= req.action;
                s_position <= req.position;
                s_value    <= req.value;
                s_valid    <= 1'b1;
                // items go in order, so predicting on the bus matches acceptance order
                list_apply(req);
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 99) < 30) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result-side stalls
    always @(posedge aclk) begin : receiver
        if (!aresetn) begin
            m_ready      <= 1'b0;
            rx_mode      <= RX_ALWAYS;
            rx_mode_left <= 0;
            rx_pattern   <= 16'hffff;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode_left <= $urandom_range(50, 400);
                rx_mode      <= rx_mode_t'($urandom_range(0, 2));
                rx_pattern   <= 16'($urandom) | 16'h0001;
            end else begin
                rx_mode_left <= rx_mode_left - 1;
                rx_pattern   <= {rx_pattern[0], rx_pattern[15:1]};
            end
            case (rx_mode)
                RX_ALWAYS:  m_ready <= 1'b1;
                RX_RANDOM:  m_ready <= ($urandom_range(0, 3) != 0);
                default:    m_ready <= rx_pattern[0];
            endcase
        end
    end

    // monitor
    always @(posedge aclk) begin : monitor
        list_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (result_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d value %0d index %0d last %0d",
                             m_status, m_entry_value, m_entry_index, m_last);
            end else begin
                want = result_q.pop_front();
                if (m_status !== want.status || m_entry_value !== want.entry_value ||
                    m_entry_index !== want.entry_index || m_last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $write("mismatch: status %0d/%0d value %0d/%0d ",
                               want.status, m_status, want.entry_value, m_entry_value);
                        $display("index %0d/%0d last %0d/%0d (expected/actual)",
                                 want.entry_index, m_entry_index, want.last, m_last);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

endmodule
